[rtl/tplw_pkg.sv]
// Shared types, constants, glyph width table and helpers for the page line wrapper.
package tplw_pkg;

   // Fixed field widths
   localparam int ROW_PX_W    = 10;
   localparam int ROWS_W      = 6;
   localparam int WIDE_PX_W   = 6;
   localparam int PAGE_OFS_W  = 24;
   localparam int NEXT_OFS_W  = 25;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int SKIP_W      = 3;
   localparam int GLYPH_PX_W  = 4;
   localparam int GLYPH_IDX_W = 7;
   localparam int ONES_W      = 4;

   // Byte codes
   localparam logic [7:0] ZERO_BYTE       = 8'd0;
   localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
   localparam logic [7:0] FIRST_PRINTABLE = 8'd32;

   // Leading-one counts that classify a byte
   localparam logic [ONES_W-1:0] ONES_ASCII = 4'd0;
   localparam logic [ONES_W-1:0] ONES_CONT  = 4'd1;
   localparam logic [ONES_W-1:0] ONES_WIDE  = 4'd3;

   // Reset values of the registers
   localparam logic [ROW_PX_W-1:0]   RESET_ROW_WIDTH_LIMIT  = 10'd160;
   localparam logic [ROWS_W-1:0]     RESET_ROWS_PER_PAGE    = 6'd9;
   localparam logic [WIDE_PX_W-1:0]  RESET_WIDE_GLYPH_WIDTH = 6'd16;
   localparam logic [PAGE_OFS_W-1:0] RESET_PAGE_START       = 24'd0;

   typedef enum logic [1:0] {
      STOP_END_OF_DATA = 2'd0,
      STOP_PAGE_FULL   = 2'd1,
      STOP_STRAY_CONT  = 2'd2,
      STOP_TRUNCATED   = 2'd3
   } stop_cause_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_WIDTH_LIMIT   = 2'd0,
      CSR_ROWS_PER_PAGE     = 2'd1,
      CSR_WIDE_GLYPH_WIDTH  = 2'd2,
      CSR_PAGE_START_OFFSET = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ROW_PX_W-1:0]  row_width_limit;
      logic [ROWS_W-1:0]    rows_per_page;
      logic [WIDE_PX_W-1:0] wide_glyph_width;
   } layout_cfg_type;

   // Pixel width of printable ASCII, space first; delete has zero width
   localparam logic [GLYPH_PX_W-1:0] GLYPH_PX [0:95] = '{
      4'd3, 4'd3, 4'd4, 4'd7, 4'd7, 4'd11, 4'd9, 4'd3, 4'd5, 4'd4, 4'd5, 4'd7, 4'd3, 4'd4,
      4'd3, 4'd3,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd3, 4'd3, 4'd7, 4'd7,
      4'd7, 4'd7,
      4'd13, 4'd7, 4'd8, 4'd9, 4'd9, 4'd8, 4'd7, 4'd9, 4'd9, 4'd3, 4'd6, 4'd9, 4'd8, 4'd9,
      4'd9, 4'd9,
      4'd8, 4'd9, 4'd9, 4'd8, 4'd7, 4'd9, 4'd7, 4'd7, 4'd7, 4'd7, 4'd4, 4'd3, 4'd3, 4'd5,
      4'd7, 4'd4,
      4'd7, 4'd7, 4'd6, 4'd7, 4'd7, 4'd4, 4'd7, 4'd7, 4'd3, 4'd3, 4'd7, 4'd3, 4'd7, 4'd7,
      4'd7, 4'd7,
      4'd5, 4'd7, 4'd3, 4'd7, 4'd5, 4'd9, 4'd5, 4'd5, 4'd5, 4'd4, 4'd3, 4'd5, 4'd8, 4'd0,
      4'd0, 4'd0
   };

   // Number of leading ones in a byte, 0..8
   function automatic logic [ONES_W-1:0] leading_ones(input logic [7:0] b);
      logic [ONES_W-1:0] n;
      logic              run;
      n   = '0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + ONES_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

[rtl/tplw_layout.sv]
// Layout state and combinational per-byte update: glyph width, row wrap, page stop.
module tplw_layout
   import tplw_pkg::*;
#(
   parameter int  PAGE_BYTES = 512,
   localparam int POS_W      = $clog2(PAGE_BYTES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           text_byte,
   input  logic                 last_byte,
   input  layout_cfg_type       cfg,
   output logic [POS_W-1:0]     rep_break_row,
   output logic [POS_W-1:0]     rep_halt_pos,
   output logic [ROWS_W-1:0]    rep_rows,
   output stop_cause_type       rep_cause
);

   localparam logic [POS_W-1:0] PAGE_LIMIT = POS_W'(PAGE_BYTES);

   // Layout state
   logic [ROW_PX_W-1:0] pen_width_ff, pen_width_in;
   logic [ROWS_W-1:0]   row_count_ff, row_count_in;
   logic [POS_W-1:0]    byte_position_ff, byte_position_in;
   logic [POS_W-1:0]    row_break_mark_ff, row_break_mark_in;
   logic [SKIP_W-1:0]   skip_remaining_ff, skip_remaining_in;
   logic                halted_ff, halted_in;
   stop_cause_type      halt_reason_ff, halt_reason_in;
   logic [POS_W-1:0]    halt_position_ff, halt_position_in;
   logic [POS_W-1:0]    lead_offset_ff, lead_offset_in;
   logic                lead_is_wide_ff, lead_is_wide_in;

   // Updated values before the end-of-page clear
   logic [ROW_PX_W-1:0]   upd_pen;
   logic [ROWS_W-1:0]     upd_rows;
   logic [POS_W-1:0]      upd_pos;
   logic [POS_W-1:0]      upd_mark;
   logic [SKIP_W-1:0]     upd_skip;
   logic                  upd_halted;
   stop_cause_type        upd_reason;
   logic [POS_W-1:0]      upd_hpos;
   logic [POS_W-1:0]      upd_lead;
   logic                  upd_wide;

   logic [ONES_W-1:0]     ones;
   logic [7:0]            glyph_diff;
   logic [GLYPH_IDX_W-1:0] glyph_idx;
   logic [POS_W-1:0]      pos_next;
   logic                  place_en;
   logic [WIDE_PX_W-1:0]  place_px;
   logic [POS_W-1:0]      place_at;
   logic                  newline_en;
   logic                  ascii_en;
   logic [ROW_PX_W:0]     pen_sum;
   logic                  wrap;
   logic                  row_event;
   logic [POS_W-1:0]      row_start;
   logic [POS_W-1:0]      row_stop;
   logic [ROWS_W-1:0]     rows_inc;

   assign ones       = leading_ones(text_byte);
   assign glyph_diff = text_byte - FIRST_PRINTABLE;
   assign glyph_idx  = glyph_diff[GLYPH_IDX_W-1:0];
   assign pos_next   = byte_position_ff + POS_W'(1);

   // Per-byte layout update
   always_comb begin
      upd_pen    = pen_width_ff;
      upd_rows   = row_count_ff;
      upd_pos    = byte_position_ff;
      upd_mark   = row_break_mark_ff;
      upd_skip   = skip_remaining_ff;
      upd_halted = halted_ff;
      upd_reason = halt_reason_ff;
      upd_hpos   = halt_position_ff;
      upd_lead   = lead_offset_ff;
      upd_wide   = lead_is_wide_ff;
      place_en   = 1'b0;
      place_px   = '0;
      place_at   = byte_position_ff;
      newline_en = 1'b0;
      ascii_en   = 1'b0;

      // Byte classification
      if (!halted_ff) begin
         if (byte_position_ff >= PAGE_LIMIT) begin
            upd_halted = 1'b1;
            if (skip_remaining_ff != '0) begin
               upd_reason = STOP_TRUNCATED;
               upd_hpos   = lead_offset_ff;
            end else begin
               upd_reason = STOP_END_OF_DATA;
               upd_hpos   = PAGE_LIMIT;
            end
         end else if (skip_remaining_ff != '0) begin
            if (text_byte == ZERO_BYTE) begin
               upd_halted = 1'b1;
               upd_reason = STOP_TRUNCATED;
               upd_hpos   = lead_offset_ff;
            end else begin
               upd_skip = skip_remaining_ff - SKIP_W'(1);
               upd_pos  = pos_next;
               if ((skip_remaining_ff == SKIP_W'(1)) && lead_is_wide_ff) begin
                  place_en = 1'b1;
                  place_px = cfg.wide_glyph_width;
                  place_at = lead_offset_ff;
               end
            end
         end else if (text_byte == ZERO_BYTE) begin
            upd_halted = 1'b1;
            upd_reason = STOP_END_OF_DATA;
            upd_hpos   = byte_position_ff;
         end else if (ones == ONES_CONT) begin
            upd_halted = 1'b1;
            upd_reason = STOP_STRAY_CONT;
            upd_hpos   = byte_position_ff;
         end else if (ones == ONES_ASCII) begin
            ascii_en = 1'b1;
            if (text_byte == NEWLINE_BYTE) begin
               newline_en = 1'b1;
            end else if (text_byte >= FIRST_PRINTABLE) begin
               place_en = 1'b1;
               place_px = WIDE_PX_W'(GLYPH_PX[glyph_idx]);
            end
         end else begin
            upd_lead = byte_position_ff;
            upd_skip = SKIP_W'(ones - ONES_W'(1));
            upd_wide = (ones == ONES_WIDE);
            upd_pos  = pos_next;
         end
      end

      // Glyph placement and row wrap
      pen_sum = (ROW_PX_W + 1)'(pen_width_ff) + (ROW_PX_W + 1)'(place_px);
      wrap    = place_en && (pen_sum > (ROW_PX_W + 1)'(cfg.row_width_limit));
      if (place_en) begin
         upd_pen = wrap ? ROW_PX_W'(place_px) : pen_sum[ROW_PX_W-1:0];
      end
      if (newline_en) begin
         upd_pen = '0;
      end
      row_event = newline_en || wrap;
      row_start = newline_en ? pos_next : place_at;
      row_stop  = newline_en ? byte_position_ff : place_at;
      rows_inc  = row_count_ff + ROWS_W'(1);
      if (row_event) begin
         upd_rows = rows_inc;
         if ((cfg.rows_per_page != '0) && (rows_inc == cfg.rows_per_page - ROWS_W'(1))) begin
            upd_mark = row_start;
         end
         if (rows_inc >= cfg.rows_per_page) begin
            upd_halted = 1'b1;
            upd_reason = STOP_PAGE_FULL;
            upd_hpos   = row_stop;
         end
      end
      if (ascii_en && !upd_halted) begin
         upd_pos = pos_next;
      end

      // Last byte closes the page
      if (last_byte && !halted_ff && !upd_halted) begin
         upd_halted = 1'b1;
         if (upd_skip != '0) begin
            upd_reason = STOP_TRUNCATED;
            upd_hpos   = upd_lead;
         end else begin
            upd_reason = STOP_END_OF_DATA;
            upd_hpos   = upd_pos;
         end
      end
   end

   // Next state: hold when idle, clear after the last byte
   always_comb begin
      pen_width_in      = pen_width_ff;
      row_count_in      = row_count_ff;
      byte_position_in  = byte_position_ff;
      row_break_mark_in = row_break_mark_ff;
      skip_remaining_in = skip_remaining_ff;
      halted_in         = halted_ff;
      halt_reason_in    = halt_reason_ff;
      halt_position_in  = halt_position_ff;
      lead_offset_in    = lead_offset_ff;
      lead_is_wide_in   = lead_is_wide_ff;
      if (step_en) begin
         if (last_byte) begin
            pen_width_in      = '0;
            row_count_in      = '0;
            byte_position_in  = '0;
            row_break_mark_in = '0;
            skip_remaining_in = '0;
            halted_in         = 1'b0;
            halt_reason_in    = STOP_END_OF_DATA;
            halt_position_in  = '0;
            lead_offset_in    = '0;
            lead_is_wide_in   = 1'b0;
         end else begin
            pen_width_in      = upd_pen;
            row_count_in      = upd_rows;
            byte_position_in  = upd_pos;
            row_break_mark_in = upd_mark;
            skip_remaining_in = upd_skip;
            halted_in         = upd_halted;
            halt_reason_in    = upd_reason;
            halt_position_in  = upd_hpos;
            lead_offset_in    = upd_lead;
            lead_is_wide_in   = upd_wide;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_width_ff      <= '0;
         row_count_ff      <= '0;
         byte_position_ff  <= '0;
         row_break_mark_ff <= '0;
         skip_remaining_ff <= '0;
         halted_ff         <= 1'b0;
         halt_reason_ff    <= STOP_END_OF_DATA;
         halt_position_ff  <= '0;
         lead_offset_ff    <= '0;
         lead_is_wide_ff   <= 1'b0;
      end else begin
         pen_width_ff      <= pen_width_in;
         row_count_ff      <= row_count_in;
         byte_position_ff  <= byte_position_in;
         row_break_mark_ff <= row_break_mark_in;
         skip_remaining_ff <= skip_remaining_in;
         halted_ff         <= halted_in;
         halt_reason_ff    <= halt_reason_in;
         halt_position_ff  <= halt_position_in;
         lead_offset_ff    <= lead_offset_in;
         lead_is_wide_ff   <= lead_is_wide_in;
      end
   end

   // Report values as they stand after this byte
   assign rep_break_row = upd_mark;
   assign rep_halt_pos  = upd_hpos;
   assign rep_rows      = upd_rows;
   assign rep_cause     = upd_reason;

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && last_byte |=> byte_position_ff == '0 && !halted_ff && row_count_ff == '0)
      else $error("layout state not cleared after last byte");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= PAGE_LIMIT)
      else $error("byte position beyond page size");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff && !(step_en && last_byte) |=> halted_ff)
      else $error("halt released before last byte");
`endif

endmodule

[rtl/text_page_line_wrapper_core.sv]
// Top level of the page line wrapper: registers, input stage and result register.
// Takes one page byte per cycle, back to back, and gives one result item at the byte marked
// last: where the page stopped, how many rows were laid out, why it stopped, and where the
// next page starts (page start plus the start of the page's last row). Each byte passes
// an input register and the layout logic (table lookup, one add, one compare, row count),
// and the last byte also loads the result register, which holds the result item. A new
// byte is taken every cycle; the only stall comes when a last byte finds an earlier result
// still held by rsp_stall. The user must see that configuration is written only while the
// block is idle; the block itself does not enforce it. There is no clearing pass after reset.
module text_page_line_wrapper_core
   import tplw_pkg::*;
#(
   parameter int  PAGE_BYTES = 512,
   localparam int POS_W      = $clog2(PAGE_BYTES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   // Byte input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_last_byte,
   // Result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NEXT_OFS_W-1:0]  rsp_next_page_offset,
   output logic [POS_W-1:0]       rsp_break_row_offset,
   output logic [POS_W-1:0]       rsp_consumed_bytes,
   output logic [ROWS_W-1:0]      rsp_rows_completed,
   output logic [1:0]             rsp_stop_cause
);

   // Configuration registers
   logic [ROW_PX_W-1:0]   row_width_limit_ff, row_width_limit_in;
   logic [ROWS_W-1:0]     rows_per_page_ff, rows_per_page_in;
   logic [WIDE_PX_W-1:0]  wide_glyph_width_ff, wide_glyph_width_in;
   logic [PAGE_OFS_W-1:0] page_start_ff, page_start_in;
   layout_cfg_type        cfg;

   // Input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;
   logic       req_take;
   logic       step;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NEXT_OFS_W-1:0] rsp_next_ofs_ff, rsp_next_ofs_in;
   logic [POS_W-1:0]      rsp_break_ff, rsp_break_in;
   logic [POS_W-1:0]      rsp_consumed_ff, rsp_consumed_in;
   logic [ROWS_W-1:0]     rsp_rows_ff, rsp_rows_in;
   stop_cause_type        rsp_cause_ff, rsp_cause_in;

   logic [POS_W-1:0]      rep_break_row;
   logic [POS_W-1:0]      rep_halt_pos;
   logic [ROWS_W-1:0]     rep_rows;
   stop_cause_type        rep_cause;

   // Register writes
   always_comb begin
      row_width_limit_in  = row_width_limit_ff;
      rows_per_page_in    = rows_per_page_ff;
      wide_glyph_width_in = wide_glyph_width_ff;
      page_start_in       = page_start_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_WIDTH_LIMIT:   row_width_limit_in  = csr_write_data[ROW_PX_W-1:0];
            CSR_ROWS_PER_PAGE:     rows_per_page_in    = csr_write_data[ROWS_W-1:0];
            CSR_WIDE_GLYPH_WIDTH:  wide_glyph_width_in = csr_write_data[WIDE_PX_W-1:0];
            CSR_PAGE_START_OFFSET: page_start_in       = csr_write_data[PAGE_OFS_W-1:0];
            default:               page_start_in       = page_start_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_limit_ff  <= RESET_ROW_WIDTH_LIMIT;
         rows_per_page_ff    <= RESET_ROWS_PER_PAGE;
         wide_glyph_width_ff <= RESET_WIDE_GLYPH_WIDTH;
         page_start_ff       <= RESET_PAGE_START;
      end else begin
         row_width_limit_ff  <= row_width_limit_in;
         rows_per_page_ff    <= rows_per_page_in;
         wide_glyph_width_ff <= wide_glyph_width_in;
         page_start_ff       <= page_start_in;
      end
   end

   assign cfg.row_width_limit  = row_width_limit_ff;
   assign cfg.rows_per_page    = rows_per_page_ff;
   assign cfg.wide_glyph_width = wide_glyph_width_ff;

   // Handshake: a held item moves on unless it is a last byte facing a stalled result
   assign step      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
         in_last_in  = req_last_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   tplw_layout #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_layout (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step),
      .text_byte     (in_byte_ff),
      .last_byte     (in_last_ff),
      .cfg           (cfg),
      .rep_break_row (rep_break_row),
      .rep_halt_pos  (rep_halt_pos),
      .rep_rows      (rep_rows),
      .rep_cause     (rep_cause)
   );

   // Result register, loaded by a last byte
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_next_ofs_in = rsp_next_ofs_ff;
      rsp_break_in    = rsp_break_ff;
      rsp_consumed_in = rsp_consumed_ff;
      rsp_rows_in     = rsp_rows_ff;
      rsp_cause_in    = rsp_cause_ff;
      if (step && in_last_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_next_ofs_in = NEXT_OFS_W'(page_start_ff) + NEXT_OFS_W'(rep_break_row);
         rsp_break_in    = rep_break_row;
         rsp_consumed_in = rep_halt_pos;
         rsp_rows_in     = rep_rows;
         rsp_cause_in    = rep_cause;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_next_ofs_ff <= rsp_next_ofs_in;
      rsp_break_ff    <= rsp_break_in;
      rsp_consumed_ff <= rsp_consumed_in;
      rsp_rows_ff     <= rsp_rows_in;
      rsp_cause_ff    <= rsp_cause_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_next_page_offset = rsp_next_ofs_ff;
   assign rsp_break_row_offset = rsp_break_ff;
   assign rsp_consumed_bytes   = rsp_consumed_ff;
   assign rsp_rows_completed   = rsp_rows_ff;
   assign rsp_stop_cause       = rsp_cause_ff;

`ifndef SYNTHESIS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      step && in_last_ff |=> rsp_valid_ff)
      else $error("last byte gave no result");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(step && in_last_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("result appeared without a last byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(step && in_last_ff))
      else $error("held result overwritten");
`endif

endmodule

[tb/tb.sv]
// Testbench for the page line wrapper: page stimulus, layout prediction and result checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tplw_pkg::*;

   localparam int          PAGE_LIMIT   = 512;
   localparam int          ITEM_TARGET  = 1050;
   localparam int          PAGE_TARGET  = 40;
   localparam int          HOLD_CYCLES  = 60;
   localparam int          QUIET_LIMIT  = 2000;
   localparam logic [7:0]  LINE_FEED    = 8'h0A;
   localparam logic [7:0]  DELETE_CHAR  = 8'h7F;

   // Pixel widths of bytes 32..127, space first
   localparam logic [3:0] GLYPH_WIDTH [96] = '{
      4'd3, 4'd3, 4'd4, 4'd7, 4'd7, 4'd11, 4'd9, 4'd3, 4'd5, 4'd4, 4'd5, 4'd7, 4'd3, 4'd4,
      4'd3, 4'd3, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd3, 4'd3,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd13, 4'd7, 4'd8, 4'd9, 4'd9, 4'd8, 4'd7, 4'd9, 4'd9, 4'd3,
      4'd6, 4'd9, 4'd8, 4'd9, 4'd9, 4'd9, 4'd8, 4'd9, 4'd9, 4'd8, 4'd7, 4'd9, 4'd7, 4'd7,
      4'd7, 4'd7, 4'd4, 4'd3, 4'd3, 4'd5, 4'd7, 4'd4, 4'd7, 4'd7, 4'd6, 4'd7, 4'd7, 4'd4,
      4'd7, 4'd7, 4'd3, 4'd3, 4'd7, 4'd3, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd7, 4'd3, 4'd7,
      4'd5, 4'd9, 4'd5, 4'd5, 4'd5, 4'd4, 4'd3, 4'd5, 4'd8, 4'd0, 4'd0, 4'd0
   };

   typedef struct {
      logic [NEXT_OFS_W-1:0] next_ofs;
      logic [9:0]            break_ofs;
      logic [9:0]            consumed;
      logic [ROWS_W-1:0]     rows;
      stop_cause_type        cause;
   } page_report_type;

   // Leading ones of a byte, 0..8
   function automatic int unsigned count_lead_ones(logic [7:0] b);
      int unsigned n;
      n = 0;
      while (n < 8 && b[7 - n]) n++;
      return n;
   endfunction

   // Layout tracker: follows the page state per byte and queues the expected page reports
   class layout_scoreboard;
      logic [ROW_PX_W-1:0]   row_limit;
      logic [ROWS_W-1:0]     page_rows;
      logic [WIDE_PX_W-1:0]  wide_px;
      logic [PAGE_OFS_W-1:0] page_base;
      logic [9:0]            pen;
      logic [ROWS_W-1:0]     rows;
      logic [9:0]            pos;
      logic [9:0]            break_mark;
      logic [2:0]            owed;
      bit                    stopped;
      stop_cause_type        reason;
      logic [9:0]            stop_pos;
      logic [9:0]            lead_pos;
      bit                    lead_wide;
      page_report_type       expected_reports[$];
      int unsigned           mismatches;
      int unsigned           active_bytes;

      function new();
         row_limit    = 10'd160;
         page_rows    = 6'd9;
         wide_px      = 6'd16;
         page_base    = '0;
         mismatches   = 0;
         active_bytes = 0;
         clear_page();
      endfunction

      function void set_regs(logic [9:0] lim, logic [5:0] nrows, logic [5:0] wide,
                             logic [23:0] base);
         row_limit = lim;
         page_rows = nrows;
         wide_px   = wide;
         page_base = base;
      endfunction

      function void clear_page();
         pen        = '0;
         rows       = '0;
         pos        = '0;
         break_mark = '0;
         owed       = '0;
         stopped    = 1'b0;
         reason     = STOP_END_OF_DATA;
         stop_pos   = '0;
         lead_pos   = '0;
         lead_wide  = 1'b0;
      endfunction

      function void halt(stop_cause_type cause, logic [9:0] where);
         stopped  = 1'b1;
         reason   = cause;
         stop_pos = where;
      endfunction

      // New row starting at row_start; a full page stops at stop_at
      function void start_row(logic [9:0] row_start, logic [9:0] stop_at);
         rows = rows + 6'd1;
         if (page_rows != 0 && rows == page_rows - 6'd1) break_mark = row_start;
         if (rows >= page_rows) halt(STOP_PAGE_FULL, stop_at);
      endfunction

      function void place_glyph(logic [5:0] px, logic [9:0] at);
         logic [10:0] reach;
         reach = {1'b0, pen} + 11'(px);
         if (reach <= {1'b0, row_limit}) begin
            pen = reach[9:0];
         end else begin
            pen = 10'(px);
            start_row(at, at);
         end
      endfunction

      // One accepted byte; queues a report on the last byte of a page
      function void lay_out_byte(logic [7:0] b, logic last);
         logic [9:0]      at;
         int unsigned     ones;
         page_report_type rep;
         at = pos;
         if (!stopped) begin
            active_bytes++;
            if (at >= 10'(PAGE_LIMIT)) begin
               if (owed != 0) halt(STOP_TRUNCATED, lead_pos);
               else halt(STOP_END_OF_DATA, 10'(PAGE_LIMIT));
            end else if (owed != 0) begin
               if (b == 8'h00) begin
                  halt(STOP_TRUNCATED, lead_pos);
               end else begin
                  owed = owed - 3'd1;
                  pos  = at + 10'd1;
                  // wide glyph lands at its lead once complete
                  if (owed == 0 && lead_wide) place_glyph(wide_px, lead_pos);
               end
            end else if (b == 8'h00) begin
               halt(STOP_END_OF_DATA, at);
            end else begin
               ones = count_lead_ones(b);
               if (ones == 1) begin
                  halt(STOP_STRAY_CONT, at);
               end else if (ones == 0) begin
                  if (b == LINE_FEED) begin
                     pen = '0;
                     start_row(at + 10'd1, at);
                  end else if (b >= 8'd32) begin
                     place_glyph(6'(GLYPH_WIDTH[b - 8'd32]), at);
                  end
                  if (!stopped) pos = at + 10'd1;
               end else begin
                  lead_pos  = at;
                  owed      = 3'(ones - 1);
                  lead_wide = (ones == 3);
                  pos       = at + 10'd1;
               end
            end
            if (last && !stopped) begin
               if (owed != 0) halt(STOP_TRUNCATED, lead_pos);
               else halt(STOP_END_OF_DATA, pos);
            end
         end
         if (last) begin
            rep.next_ofs  = 25'(page_base) + 25'(break_mark);
            rep.break_ofs = break_mark;
            rep.consumed  = stop_pos;
            rep.rows      = rows;
            rep.cause     = reason;
            expected_reports.push_back(rep);
            clear_page();
         end
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_report(logic [NEXT_OFS_W-1:0] next_ofs, logic [9:0] brk,
                                 logic [9:0] cons, logic [ROWS_W-1:0] nrows,
                                 logic [1:0] cause);
         page_report_type want;
         if (expected_reports.size() == 0) begin
            mismatches++;
            $display("%0t: result item with no page pending, expected none, got %0d/%0d/%0d",
                     $time, next_ofs, cons, cause);
            return;
         end
         want = expected_reports.pop_front();
         field_check("next_page_offset", 32'(want.next_ofs), 32'(next_ofs));
         field_check("break_row_offset", 32'(want.break_ofs), 32'(brk));
         field_check("consumed_bytes", 32'(want.consumed), 32'(cons));
         field_check("rows_completed", 32'(want.rows), 32'(nrows));
         field_check("stop_cause", 32'(want.cause), 32'(cause));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_text_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [NEXT_OFS_W-1:0]  rsp_next_page_offset;
   logic [9:0]             rsp_break_row_offset;
   logic [9:0]             rsp_consumed_bytes;
   logic [ROWS_W-1:0]      rsp_rows_completed;
   logic [1:0]             rsp_stop_cause;

   layout_scoreboard board;
   logic [7:0]       page_text[$];
   int unsigned      sender_idle_pct = 0;
   int unsigned      stall_pct = 0;
   int unsigned      hold_token = 0;
   int unsigned      hold_seen = 0;
   int unsigned      hold_left = 0;

   text_page_line_wrapper_core DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_next_page_offset (rsp_next_page_offset),
      .rsp_break_row_offset (rsp_break_row_offset),
      .rsp_consumed_bytes   (rsp_consumed_bytes),
      .rsp_rows_completed   (rsp_rows_completed),
      .rsp_stop_cause       (rsp_stop_cause)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.lay_out_byte(req_text_byte, req_last_byte);
         if (rsp_valid && !rsp_stall)
            board.check_report(rsp_next_page_offset, rsp_break_row_offset,
                               rsp_consumed_bytes, rsp_rows_completed, rsp_stop_cause);
      end
   end

   // Ends the run when nothing moves for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_page();
      for (int i = 0; i < page_text.size(); i++)
         send_byte(page_text[i], i == page_text.size() - 1);
   endtask

   // Sender stops until every page report has come back
   task automatic wait_reports_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.expected_reports.size() != 0);
   endtask

   task automatic load_layout_regs(input logic [9:0] lim, input logic [5:0] nrows,
                                   input logic [5:0] wide, input logic [23:0] base);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ROW_WIDTH_LIMIT;
      csr_write_data   <= 24'(lim);
      @(negedge clock);
      csr_index        <= CSR_ROWS_PER_PAGE;
      csr_write_data   <= 24'(nrows);
      @(negedge clock);
      csr_index        <= CSR_WIDE_GLYPH_WIDTH;
      csr_write_data   <= 24'(wide);
      @(negedge clock);
      csr_index        <= CSR_PAGE_START_OFFSET;
      csr_write_data   <= base;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_regs(lim, nrows, wide, base);
   endtask

   function automatic void push_continuations(int unsigned n);
      for (int i = 0; i < n; i++) page_text.push_back({2'b10, 6'($urandom)});
   endfunction

   // Random page: clean pages hold whole sequences, broken ones carry noise and get cut
   function automatic void compose_page(int unsigned len, bit clean);
      int unsigned pick;
      page_text.delete();
      while (page_text.size() < len) begin
         pick = clean ? $urandom_range(84) : $urandom_range(99);
         if (pick < 55) begin
            page_text.push_back(8'($urandom_range(126, 32)));
         end else if (pick < 63) begin
            page_text.push_back(LINE_FEED);
         end else if (pick < 75) begin
            page_text.push_back({4'hE, 4'($urandom)});
            push_continuations(2);
         end else if (pick < 79) begin
            page_text.push_back({3'b110, 5'($urandom)});
            push_continuations(1);
         end else if (pick < 82) begin
            page_text.push_back({5'b11110, 3'($urandom)});
            push_continuations(3);
         end else if (pick < 85) begin
            page_text.push_back(($urandom_range(3) == 0) ? DELETE_CHAR
                                                          : 8'($urandom_range(31, 1)));
         end else if (pick < 89) begin
            page_text.push_back({2'b10, 6'($urandom)});
         end else if (pick < 92) begin
            page_text.push_back(8'h00);
         end else if (pick < 95) begin
            page_text.push_back({5'b11111, 3'($urandom)});
            push_continuations($urandom_range(7));
         end else begin
            page_text.push_back(8'($urandom));
         end
      end
      if (!clean)
         while (page_text.size() > len) void'(page_text.pop_back());
   endfunction

   function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
                                                int unsigned mid_lo, int unsigned mid_hi);
      case ($urandom_range(4))
         0: return lo;
         1: return hi;
         default: return $urandom_range(mid_hi, mid_lo);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned phase;
      int unsigned pages_done;
      board = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed pages at the reset settings
      page_text = '{8'h20, 8'h7E, DELETE_CHAR, 8'h01, 8'h1F, LINE_FEED, 8'hE4, 8'hB8, 8'hAD,
                    8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41};
      send_page();
      page_text = '{8'h80, 8'h41};        // stray continuation, rest ignored
      send_page();
      page_text = '{8'hEF, 8'hBF};        // wide glyph cut by the last byte
      send_page();
      page_text = '{8'h5A, 8'h00, 8'h41}; // zero byte ends the data
      send_page();
      page_text = '{8'hE2, 8'h00};        // wide glyph cut by a zero byte
      send_page();
      page_text = '{8'hFF};               // eight-ones lead left open
      send_page();

      phase      = 0;
      pages_done = 0;
      while (board.active_bytes < ITEM_TARGET || pages_done < PAGE_TARGET) begin
         // settle before touching the registers
         req_valid <= 1'b0;
         do @(negedge clock); while (board.expected_reports.size() != 0);
         repeat (4) @(negedge clock);
         if (phase == 0)
            load_layout_regs(10'd1023, 6'd63, 6'd63, 24'hFFFFFF);
         else if (phase == 1)
            load_layout_regs(10'd1, 6'd2, 6'd1, 24'h000000);
         else
            load_layout_regs(10'(pick_setting(1, 1023, 20, 200)),
                             6'(pick_setting(2, 63, 2, 12)),
                             6'(pick_setting(1, 63, 1, 63)),
                             24'(pick_setting(0, 24'hFFFFFF, 0, 24'hFFFFFF)));
         case (phase % 4)
            0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
            1: begin sender_idle_pct = 80; stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  stall_pct <= 80; end
            default: begin sender_idle_pct = 17; stall_pct <= 17; end
         endcase

         if (phase == 0) begin
            // overrun past the page size
            page_text.delete();
            for (int i = 0; i < PAGE_LIMIT + 2; i++)
               page_text.push_back(8'($urandom_range(126, 33)));
            send_page();
            // wide glyph cut by the page size
            page_text.delete();
            for (int i = 0; i < PAGE_LIMIT - 1; i++)
               page_text.push_back(8'($urandom_range(126, 33)));
            page_text.push_back(8'hE4);
            page_text.push_back(8'hB8);
            send_page();
         end

         for (int k = 0; k < 10; k++) begin
            if (k == 5) begin
               // long hold-off on results while tiny pages keep coming
               hold_token <= hold_token + 1;
               for (int j = 0; j < 6; j++) begin
                  compose_page($urandom_range(3, 1), 1'b1);
                  send_page();
               end
               wait_reports_drained();
            end
            compose_page($urandom_range(24, 1), $urandom_range(9) < 7);
            send_page();
            pages_done++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (board.expected_reports.size() != 0);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.expected_reports.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/tplw_pkg.sv
rtl/tplw_layout.sv
rtl/text_page_line_wrapper_core.sv
tb/tb.sv
